FILE: sv/threshold_window_average_core_defines.svh
// Assertion macros shared by the checker of the thresholded window mean core.
// No dependencies; expects clk and rst_n in the scope where a macro is used.
`ifndef THRESHOLD_WINDOW_AVERAGE_CORE_DEFINES_SVH
`define THRESHOLD_WINDOW_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TWA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TWA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/twa_pkg.sv
// Shared field widths, register indexes, opcodes and controller/datapath structs.
// No dependencies.
package twa_pkg;

    localparam int COL_W      = 8;
    localparam int ROW_W      = 8;
    localparam int AVG_W      = 24;
    localparam int CNT_W      = 8;
    localparam int OUT_W      = AVG_W + CNT_W;
    localparam int FRAC_BITS  = 8;

    localparam int SIZE_REG_W = 9;
    localparam int RAD_REG_W  = 3;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd4;

    localparam logic [SIZE_REG_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [SIZE_REG_W-1:0] RST_IMAGE_HEIGHT = 9'd256;
    localparam logic [RAD_REG_W-1:0]  RST_RADIUS_X     = 3'd1;
    localparam logic [RAD_REG_W-1:0]  RST_RADIUS_Y     = 3'd1;
    localparam logic [THR_W-1:0]      RST_THRESHOLD    = 16'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;            // input transfer this cycle
        logic read_center;     // issue frame read at the query center
        logic capture_center;  // latch center pixel from read data
        logic scan_read;       // issue frame read at the scan position, advance
        logic div_start;       // load the divider from sum and count
        logic div_run;         // one restoring division step
        logic out_load;        // load the output register
    } twa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic in_image;
        logic scan_last;
        logic div_last;
    } twa_sts_t;

endpackage

FILE: sv/twa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module twa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/twa_ctrl.sv
// Controller state machine: sequences center read, window scan, division, result.
// Depends on twa_pkg.
module twa_ctrl
    import twa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  twa_sts_t sts,
    output twa_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;
    localparam logic [2:0] S_CWAIT  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd                = '0;
        cmd.take           = s_tvalid && (state_reg == S_IDLE);
        cmd.read_center    = (state_reg == S_CENTER);
        cmd.capture_center = (state_reg == S_CWAIT);
        cmd.scan_read      = (state_reg == S_SCAN);
        cmd.div_start      = (state_reg == S_DSTART);
        cmd.div_run        = (state_reg == S_DIV);
        cmd.out_load       = (state_reg == S_RESULT) && (!out_valid_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take && sts.is_query)
                begin
                    state_next = sts.in_image ? S_CENTER : S_RESULT;
                end
            end
            S_CENTER: state_next = S_CWAIT;
            S_CWAIT:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

FILE: sv/twa_datapath.sv
// Datapath: configuration registers, frame memory, window scan counters,
// thresholded accumulator, restoring divider and output register.
// Depends on twa_pkg and twa_ram.
module twa_datapath
    import twa_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7,
    parameter int PIXEL_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_op,
    input  logic [COL_W-1:0]             in_col,
    input  logic [ROW_W-1:0]             in_row,
    input  logic signed [PIXEL_BITS-1:0] in_pixel,
    input  twa_cmd_t                     cmd,
    output twa_sts_t                     sts,
    output logic signed [AVG_W-1:0]      out_average,
    output logic [CNT_W-1:0]             out_count,
    output logic                         out_bad
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SZWX  = (WW > SIZE_REG_W) ? WW : SIZE_REG_W;
    localparam int SZWY  = (HW > SIZE_REG_W) ? HW : SIZE_REG_W;
    localparam int RADW  = (RW > RAD_REG_W) ? RW : RAD_REG_W;
    localparam int CMX   = (WW > COL_W) ? WW : COL_W;
    localparam int CMY   = (HW > ROW_W) ? HW : ROW_W;
    localparam int PWX   = ((XW > RW) ? XW : RW) + 1;
    localparam int PWY   = ((YW > RW) ? YW : RW) + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NMAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int NW    = $clog2(NMAX + 1);
    localparam int SW    = PIXEL_BITS + NW;
    localparam int DW    = SW - 1 + FRAC_BITS;
    localparam int DCW   = $clog2(DW + 1);
    localparam int DIFW  = PIXEL_BITS + 1;
    localparam int THW   = (DIFW > THR_W) ? DIFW : THR_W;

    // Configuration
    logic [SIZE_REG_W-1:0] width_reg;
    logic [SIZE_REG_W-1:0] height_reg;
    logic [RAD_REG_W-1:0]  radx_reg;
    logic [RAD_REG_W-1:0]  rady_reg;
    logic [THR_W-1:0]      thr_reg;

    logic [SZWX-1:0] wide_w;
    logic [SZWY-1:0] wide_h;
    logic [RADW-1:0] wide_rx;
    logic [RADW-1:0] wide_ry;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [RW-1:0]   rx_eff;
    logic [RW-1:0]   ry_eff;

    // Query bounds
    logic          in_image;
    logic [XW-1:0] col_c;
    logic [YW-1:0] row_c;
    logic [PWX-1:0] colp, rxp, wm1, bxsum;
    logic [PWY-1:0] rowp, ryp, hm1, bysum;
    logic [XW-1:0] ax_c, bx_c;
    logic [YW-1:0] ay_c, by_c;

    logic [XW-1:0] col_reg, ax_reg, bx_reg, ix_reg;
    logic [YW-1:0] row_reg, ay_reg, by_reg, iy_reg;
    logic          bad_reg;

    // Memory
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [XW-1:0]                rd_x;
    logic [YW-1:0]                rd_y;
    logic [PIXEL_BITS-1:0]        ram_rdata;
    logic signed [PIXEL_BITS-1:0] pix_rd;

    // Accumulation
    logic signed [PIXEL_BITS-1:0] center_reg;
    logic signed [SW-1:0]         sum_reg;
    logic [NW-1:0]                cnt_reg;
    logic                         acc_valid_reg;
    logic signed [DIFW-1:0]       diff;
    logic [DIFW-1:0]              adiff;
    logic                         in_thr;

    // Division
    logic [SW-1:0]    sum_mag;
    logic             neg_reg;
    logic [DW-1:0]    dvd_reg;
    logic [NW-1:0]    rem_reg;
    logic [AVG_W-1:0] quo_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [NW:0]      rem_sh;
    logic [NW:0]      den;
    logic             ge;

    // Clamp the configured sizes and radii.
    assign wide_w  = SZWX'(width_reg);
    assign wide_h  = SZWY'(height_reg);
    assign wide_rx = RADW'(radx_reg);
    assign wide_ry = RADW'(rady_reg);

    always_comb
    begin
        if (wide_w == '0)
            w_eff = WW'(1);
        else if (wide_w > SZWX'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(wide_w);

        if (wide_h == '0)
            h_eff = HW'(1);
        else if (wide_h > SZWY'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(wide_h);

        rx_eff = (wide_rx > RADW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(wide_rx);
        ry_eff = (wide_ry > RADW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(wide_ry);
    end

    assign in_image = (CMX'(in_col) < CMX'(w_eff)) && (CMY'(in_row) < CMY'(h_eff));
    assign col_c    = XW'(in_col);
    assign row_c    = YW'(in_row);

    // Window clipped at the image edges.
    assign colp  = PWX'(col_c);
    assign rxp   = PWX'(rx_eff);
    assign wm1   = PWX'(w_eff) - PWX'(1);
    assign bxsum = colp + rxp;
    assign ax_c  = (colp >= rxp) ? XW'(colp - rxp) : '0;
    assign bx_c  = (bxsum > wm1) ? XW'(wm1) : XW'(bxsum);

    assign rowp  = PWY'(row_c);
    assign ryp   = PWY'(ry_eff);
    assign hm1   = PWY'(h_eff) - PWY'(1);
    assign bysum = rowp + ryp;
    assign ay_c  = (rowp >= ryp) ? YW'(rowp - ryp) : '0;
    assign by_c  = (bysum > hm1) ? YW'(hm1) : YW'(bysum);

    // Frame memory, row-major at MAX_WIDTH pitch.
    assign ram_we    = cmd.take && (in_op == OP_WRITE) && in_image;
    assign ram_waddr = AW'(AW'(row_c) * AW'(MAX_WIDTH) + AW'(col_c));
    assign rd_x      = cmd.read_center ? col_reg : ix_reg;
    assign rd_y      = cmd.read_center ? row_reg : iy_reg;
    assign ram_raddr = AW'(AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x));

    twa_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_pixel),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pix_rd = ram_rdata;
    assign diff   = DIFW'(pix_rd) - DIFW'(center_reg);
    assign adiff  = diff[DIFW-1] ? DIFW'(-diff) : DIFW'(diff);
    assign in_thr = (THW'(adiff) <= THW'(thr_reg));

    // Restoring division step on the magnitude.
    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign rem_sh  = {rem_reg, dvd_reg[DW-1]};
    assign den     = {1'b0, cnt_reg};
    assign ge      = (rem_sh >= den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RST_IMAGE_WIDTH;
            height_reg    <= RST_IMAGE_HEIGHT;
            radx_reg      <= RST_RADIUS_X;
            rady_reg      <= RST_RADIUS_Y;
            thr_reg       <= RST_THRESHOLD;
            acc_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[SIZE_REG_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[SIZE_REG_W-1:0];
                    CFG_RADIUS_X:     radx_reg   <= cfg_data[RAD_REG_W-1:0];
                    CFG_RADIUS_Y:     rady_reg   <= cfg_data[RAD_REG_W-1:0];
                    CFG_THRESHOLD:    thr_reg    <= cfg_data[THR_W-1:0];
                    default:          ;
                endcase
            end
            acc_valid_reg <= cmd.scan_read;
            if (cmd.div_start)
                div_cnt_reg <= DCW'(DW);
            else if (cmd.div_run)
                div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && (in_op == OP_QUERY))
        begin
            col_reg <= col_c;
            row_reg <= row_c;
            ax_reg  <= ax_c;
            bx_reg  <= bx_c;
            ay_reg  <= ay_c;
            by_reg  <= by_c;
            ix_reg  <= ax_c;
            iy_reg  <= ay_c;
            bad_reg <= !in_image;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.scan_read)
            begin
                if (ix_reg == bx_reg)
                begin
                    ix_reg <= ax_reg;
                    iy_reg <= iy_reg + YW'(1);
                end
                else
                begin
                    ix_reg <= ix_reg + XW'(1);
                end
            end
            if (acc_valid_reg && in_thr)
            begin
                sum_reg <= sum_reg + SW'(pix_rd);
                cnt_reg <= cnt_reg + NW'(1);
            end
        end

        if (cmd.capture_center)
            center_reg <= pix_rd;

        if (cmd.div_start)
        begin
            neg_reg <= sum_reg[SW-1];
            dvd_reg <= {sum_mag[SW-2:0], {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_run)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge ? NW'(rem_sh - den) : NW'(rem_sh);
            quo_reg <= {quo_reg[AVG_W-2:0], ge};
        end

        if (cmd.out_load)
        begin
            out_bad     <= bad_reg;
            out_average <= bad_reg ? '0 : (neg_reg ? AVG_W'(-quo_reg) : AVG_W'(quo_reg));
            out_count   <= bad_reg ? '0 : CNT_W'(cnt_reg);
        end
    end

    assign sts.is_query  = (in_op == OP_QUERY);
    assign sts.in_image  = in_image;
    assign sts.scan_last = (ix_reg == bx_reg) && (iy_reg == by_reg);
    assign sts.div_last  = (div_cnt_reg == DCW'(1));

endmodule

FILE: sv/threshold_window_average_core.sv
// Top level of the thresholded window mean core: stream ports and config port.
// Depends on twa_pkg, twa_ctrl and twa_datapath (which holds twa_ram).
// Usage:
//   Input stream (s_*): one transfer is either a pixel write (tuser = 0) or a
//   query (tuser = 1). A write stores pixel_value at (col, row) when inside
//   the configured image and yields no result. A query yields one result on
//   the output stream (m_*): the mean of window pixels within threshold of
//   the center, 8 fractional bits, truncated toward zero, plus their count.
//   A query outside the image yields bad_position = 1 with zero fields.
//   A write leaves the block idle. A query scans its clipped window: the scan
//   reads one pixel per cycle from the single frame memory read port, then a
//   one-bit-per-cycle divider forms the mean. An out-of-image query skips
//   the scan and the division and goes straight to the result.
//   s_tready is high only while idle. The result sits in an output register,
//   so the next item is taken while it waits; a stalled receiver holds the
//   following result in the block until the register frees up.
//   Reset restores the configuration defaults; frame contents are undefined
//   until written. Write configuration only while the block is idle.
module threshold_window_average_core
    import twa_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // col[7:0], row[15:8], pixel_value[16 +: PIXEL_BITS], zero padding above
    input  logic [((COL_W+ROW_W+PIXEL_BITS+7)/8)*8-1:0] s_tdata,
    // op[0]
    input  logic [0:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // average[23:0], used_count[31:24]
    output logic [OUT_W-1:0]                            m_tdata,
    // bad_position[0]
    output logic [0:0]                                  m_tuser,
    input  logic                                        cfg_we,
    input  logic [CFG_IDX_W-1:0]                        cfg_index,
    input  logic [CFG_DATA_W-1:0]                       cfg_data
);

    twa_cmd_t                     cmd;
    twa_sts_t                     sts;
    logic                         in_op;
    logic [COL_W-1:0]             in_col;
    logic [ROW_W-1:0]             in_row;
    logic signed [PIXEL_BITS-1:0] in_pixel;
    logic signed [AVG_W-1:0]      out_average;
    logic [CNT_W-1:0]             out_count;
    logic                         out_bad;

    // Unpack the input transfer; padding bits are dropped.
    assign in_op    = s_tuser[0];
    assign in_col   = s_tdata[COL_W-1:0];
    assign in_row   = s_tdata[COL_W +: ROW_W];
    assign in_pixel = s_tdata[COL_W+ROW_W +: PIXEL_BITS];

    twa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    twa_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (in_op),
        .in_col      (in_col),
        .in_row      (in_row),
        .in_pixel    (in_pixel),
        .cmd         (cmd),
        .sts         (sts),
        .out_average (out_average),
        .out_count   (out_count),
        .out_bad     (out_bad)
    );

    // Pack the result transfer.
    assign m_tdata    = {out_count, out_average};
    assign m_tuser[0] = out_bad;

endmodule

FILE: sv/twa_checker.sv
// Port-level checker for the thresholded window mean core, bound to the top.
// Depends on twa_pkg and threshold_window_average_core_defines.svh.
`include "threshold_window_average_core_defines.svh"

module twa_checker
    import twa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [0:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [0:0]       m_tuser
);

    // A stalled result holds its payload.
    `TWA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A flagged position carries zero mean and count.
    `TWA_ASSERT_IMP(a_bad_zero, m_tvalid && m_tuser[0],
        m_tdata == '0, "bad position result not zero")

    // A query transfer makes the block busy in the next cycle.
    `TWA_ASSERT_NXT(a_query_busy, s_tvalid && s_tready && (s_tuser[0] == OP_QUERY),
        !s_tready, "ready stayed high after a query")

    // A pixel write leaves the block ready in the next cycle.
    `TWA_ASSERT_NXT(a_write_free, s_tvalid && s_tready && (s_tuser[0] == OP_WRITE),
        s_tready, "ready dropped after a write")

endmodule

bind threshold_window_average_core twa_checker u_twa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
